>>> rtl/pblm_pkg.sv
// pblm_pkg: shared constants, types and helpers of the pixel band lut mapper
// no dependencies; compile first

package pblm_pkg;

    // sizing of the table store and result width
    localparam int TABLE_DEPTH = 256;
    localparam int BAND_COUNT  = 3;
    localparam int OUT_BITS    = 16;

    localparam int NUM_TABLES  = 3;
    localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PIX_W       = 8;
    localparam int FIELD_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    typedef logic [PIX_W-1:0]    t_pix;
    typedef logic [FIELD_W-1:0]  t_field;
    typedef logic [OUT_BITS-1:0] t_value;
    typedef logic [TBL_AW-1:0]   t_addr;

    // request kinds on the input channel
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_TABLE = 1'b1;

    // mode codes, the unused code behaves as per-band
    localparam logic [1:0] MODE_PER_BAND = 2'd0;
    localparam logic [1:0] MODE_EXPLODE  = 2'd1;
    localparam logic [1:0] MODE_COMBINE  = 2'd2;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_BAND_MASK   = 3'd1,
        REG_MULT0       = 3'd2,
        REG_MULT1       = 3'd3,
        REG_MULT2       = 3'd4,
        REG_ZERO_OUTPUT = 3'd5
    } t_cfg_idx;

    // register reset values
    localparam logic [1:0] MODE_RST      = MODE_PER_BAND;
    localparam logic [2:0] BAND_MASK_RST = 3'd7;
    localparam t_pix       MULT0_RST     = 8'd1;
    localparam t_pix       MULT1_RST     = 8'd0;
    localparam t_pix       MULT2_RST     = 8'd0;
    localparam logic [2:0] ZERO_OUT_RST  = 3'd0;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] band_mask;
        t_pix       mult0;
        t_pix       mult1;
        t_pix       mult2;
        logic [2:0] zero_output;
    } t_cfg;

    // per-pixel control carried beside the table read
    typedef struct packed {
        logic [1:0]                 mode;
        logic [2:0]                 band_mask;
        logic [2:0]                 zero_output;
        logic [NUM_TABLES-1:0][7:0] band;
        logic                       last;
    } t_s1_ctl;

    // byte index modulo table depth, one compare and subtract per bit
    function automatic t_addr tbl_wrap(input t_pix idx);
        logic [31:0] v;
        v = 32'(idx);
        for (int k = 7; k >= 0; k--) begin
            if (v >= (32'(TABLE_DEPTH) << k)) begin
                v = v - (32'(TABLE_DEPTH) << k);
            end
        end
        return t_addr'(v);
    endfunction

endpackage

>>> rtl/pblm_in_if.sv
// pblm_in_if: input channel, pixel beats and table write beats
// depends on pblm_pkg

interface pblm_in_if;
    import pblm_pkg::*;

    logic   valid;
    logic   ready;
    logic   req_type;
    t_pix   band0;
    t_pix   band1;
    t_pix   band2;
    logic   last_in_line;
    logic [1:0] table_select;
    t_pix   table_index;
    t_field table_value;

    modport source (
        output valid, req_type, band0, band1, band2, last_in_line,
               table_select, table_index, table_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, band0, band1, band2, last_in_line,
               table_select, table_index, table_value,
        output ready
    );
endinterface

>>> rtl/pblm_out_if.sv
// pblm_out_if: result channel, one beat per pixel
// depends on pblm_pkg

interface pblm_out_if;
    import pblm_pkg::*;

    logic   valid;
    logic   ready;
    t_field out0;
    t_field out1;
    t_field out2;
    logic   line_done;

    modport source (
        output valid, out0, out1, out2, line_done,
        input  ready
    );
    modport sink (
        input  valid, out0, out1, out2, line_done,
        output ready
    );
endinterface

>>> rtl/pblm_cfg_if.sv
// pblm_cfg_if: register write channel
// depends on pblm_pkg

interface pblm_cfg_if;
    import pblm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/pixel_band_lut_mapper_unit.sv
// pixel_band_lut_mapper_unit: top level of the pixel band lut mapper
// path: a pixel beat's table read and side data are registered in stage 1, then its
//   result beat is held in the stage 2 result register; a table write gives no beat
// throughput: one input beat per cycle, pixel or table write, unless the result channel
//   stalls; set by the single read port and single write port of each band table ram
// reset: config registers go to their defaults and the pipeline empties;
//   table contents are not cleared and are undefined until written
// depends on pblm_pkg, the channel interfaces, pblm_cfg_regs, pblm_addr_gen,
// pblm_ram and pblm_out_stage

module pixel_band_lut_mapper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pblm_in_if.sink     i_pix,
    pblm_cfg_if.sink    i_cfg,
    pblm_out_if.source  o_res
);
    import pblm_pkg::*;

    t_cfg            cfg;
    logic            in_accept;
    logic            pix_accept;
    logic            wr_accept;
    logic            s2_free;
    t_addr           rd_addr [NUM_TABLES];
    logic [NUM_TABLES-1:0] wr_en;
    t_addr           wr_addr;
    t_value          wr_data;
    t_value          rd_data [NUM_TABLES];
    t_s1_ctl         n_s1_ctl;

    // stage 1: table read in flight plus side data of the pixel
    logic            r_s1_valid;
    t_s1_ctl         r_s1_ctl;

    pblm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // stage 1 can take a new beat when empty or when it hands off this cycle
    assign i_pix.ready = !r_s1_valid || s2_free;
    assign in_accept   = i_pix.valid && i_pix.ready;
    assign pix_accept  = in_accept && (i_pix.req_type == REQ_PIXEL);
    assign wr_accept   = in_accept && (i_pix.req_type == REQ_TABLE);

    // read addresses come straight from the input beat, the ram registers them
    pblm_addr_gen u_addr_gen (
        .i_cfg          (cfg),
        .i_band0        (i_pix.band0),
        .i_band1        (i_pix.band1),
        .i_band2        (i_pix.band2),
        .i_wr_accept    (wr_accept),
        .i_table_select (i_pix.table_select),
        .i_table_index  (i_pix.table_index),
        .i_table_value  (i_pix.table_value),
        .o_rd_addr      (rd_addr),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data)
    );

    // one table ram per present band; read data holds while stage 1 stalls
    for (genvar b = 0; b < NUM_TABLES; b++) begin : g_band
        if (b < BAND_COUNT) begin : g_tbl
            pblm_ram #(
                .WIDTH (OUT_BITS),
                .DEPTH (TABLE_DEPTH)
            ) u_tbl (
                .i_clk     (i_clk),
                .i_wr_en   (wr_en[b]),
                .i_wr_addr (wr_addr),
                .i_wr_data (wr_data),
                .i_rd_en   (pix_accept),
                .i_rd_addr (rd_addr[b]),
                .o_rd_data (rd_data[b])
            );
        end else begin : g_none
            assign rd_data[b] = '0;
        end
    end

    always_comb begin
        n_s1_ctl.mode        = cfg.mode;
        n_s1_ctl.band_mask   = cfg.band_mask;
        n_s1_ctl.zero_output = cfg.zero_output;
        n_s1_ctl.band[0]     = i_pix.band0;
        n_s1_ctl.band[1]     = i_pix.band1;
        n_s1_ctl.band[2]     = i_pix.band2;
        n_s1_ctl.last        = i_pix.last_in_line;
    end

    // write beats pass through stage 1 as bubbles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= pix_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    // stage 2: band select and result register
    pblm_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (r_s1_valid),
        .i_ctl      (r_s1_ctl),
        .i_rd_data  (rd_data),
        .o_s2_free  (s2_free),
        .o_res      (o_res)
    );
endmodule

>>> rtl/pblm_ram.sv
// pblm_ram: generic single write port ram with registered read
// no dependencies

module pblm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/pblm_cfg_regs.sv
// pblm_cfg_regs: configuration register file
// depends on pblm_pkg and pblm_cfg_if

module pblm_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pblm_cfg_if.sink          i_cfg,
    output pblm_pkg::t_cfg    o_cfg
);
    import pblm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                REG_MODE:        n_cfg.mode        = i_cfg.data[1:0];
                REG_BAND_MASK:   n_cfg.band_mask   = i_cfg.data[2:0];
                REG_MULT0:       n_cfg.mult0       = i_cfg.data[7:0];
                REG_MULT1:       n_cfg.mult1       = i_cfg.data[7:0];
                REG_MULT2:       n_cfg.mult2       = i_cfg.data[7:0];
                REG_ZERO_OUTPUT: n_cfg.zero_output = i_cfg.data[2:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= MODE_RST;
            r_cfg.band_mask   <= BAND_MASK_RST;
            r_cfg.mult0       <= MULT0_RST;
            r_cfg.mult1       <= MULT1_RST;
            r_cfg.mult2       <= MULT2_RST;
            r_cfg.zero_output <= ZERO_OUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

>>> rtl/pblm_addr_gen.sv
// pblm_addr_gen: table read addresses per band and table write decode
// depends on pblm_pkg

module pblm_addr_gen (
    input  pblm_pkg::t_cfg                   i_cfg,
    input  pblm_pkg::t_pix                   i_band0,
    input  pblm_pkg::t_pix                   i_band1,
    input  pblm_pkg::t_pix                   i_band2,
    input  logic                             i_wr_accept,
    input  logic [1:0]                       i_table_select,
    input  pblm_pkg::t_pix                   i_table_index,
    input  pblm_pkg::t_field                 i_table_value,
    output pblm_pkg::t_addr                  o_rd_addr [pblm_pkg::NUM_TABLES],
    output logic [pblm_pkg::NUM_TABLES-1:0]  o_wr_en,
    output pblm_pkg::t_addr                  o_wr_addr,
    output pblm_pkg::t_value                 o_wr_data
);
    import pblm_pkg::*;

    t_pix bands [NUM_TABLES];
    t_pix mults [NUM_TABLES];
    t_pix comb_sum;

    assign bands[0] = i_band0;
    assign bands[1] = i_band1;
    assign bands[2] = i_band2;
    assign mults[0] = i_cfg.mult0;
    assign mults[1] = i_cfg.mult1;
    assign mults[2] = i_cfg.mult2;

    // weighted byte sum, only the low byte matters
    always_comb begin
        logic [15:0] prod;
        comb_sum = '0;
        for (int b = 0; b < NUM_TABLES; b++) begin
            prod = 16'(mults[b]) * 16'(bands[b]);
            if (b < BAND_COUNT) begin
                comb_sum = comb_sum + prod[7:0];
            end
        end
    end

    always_comb begin
        for (int b = 0; b < NUM_TABLES; b++) begin
            case (i_cfg.mode)
                MODE_EXPLODE: o_rd_addr[b] = tbl_wrap(bands[0]);
                MODE_COMBINE: o_rd_addr[b] = tbl_wrap(comb_sum);
                default:      o_rd_addr[b] = tbl_wrap(bands[b]);
            endcase
        end
    end

    // writes to a table that does not exist are dropped
    always_comb begin
        for (int b = 0; b < NUM_TABLES; b++) begin
            o_wr_en[b] = i_wr_accept && (i_table_select == 2'(b)) && (b < BAND_COUNT);
        end
    end

    assign o_wr_addr = tbl_wrap(i_table_index);
    assign o_wr_data = t_value'(i_table_value);
endmodule

>>> rtl/pblm_out_stage.sv
// pblm_out_stage: per-band select of table value, pass-through or zero,
// and the result register; depends on pblm_pkg and pblm_out_if

module pblm_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s1_valid,
    input  pblm_pkg::t_s1_ctl  i_ctl,
    input  pblm_pkg::t_value   i_rd_data [pblm_pkg::NUM_TABLES],
    output logic               o_s2_free,
    pblm_out_if.source         o_res
);
    import pblm_pkg::*;

    t_field n_out [NUM_TABLES];
    t_field r_out [NUM_TABLES];
    logic   r_line;
    logic   r_valid;
    logic   load;

    always_comb begin
        t_field mapped;
        t_field passed;
        for (int b = 0; b < NUM_TABLES; b++) begin
            mapped = i_ctl.zero_output[b] ? '0 : FIELD_W'(i_rd_data[b]);
            passed = FIELD_W'(t_value'(i_ctl.band[b]));
            case (i_ctl.mode)
                MODE_COMBINE: n_out[b] = (b == 0) ? mapped : '0;
                MODE_EXPLODE: n_out[b] = mapped;
                default:      n_out[b] = i_ctl.band_mask[b] ? mapped : passed;
            endcase
            if (b >= BAND_COUNT) begin
                n_out[b] = '0;
            end
        end
    end

    assign o_s2_free = !r_valid || o_res.ready;
    assign load      = i_s1_valid && o_s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s2_free) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out  <= n_out;
            r_line <= i_ctl.last;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.out0      = r_out[0];
    assign o_res.out1      = r_out[1];
    assign o_res.out2      = r_out[2];
    assign o_res.line_done = r_line;
endmodule

>>> tb/pixel_band_lut_mapper_unit_test.sv
// pixel_band_lut_mapper_unit_test: self-checking bench for the pixel band lut mapper
// drives pixel and table write beats, programs the registers between phases and
// checks every result beat against a bench model or a typed row; needs pblm_pkg, interfaces

module pixel_band_lut_mapper_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pblm_pkg::*;

    // run shape
    localparam int PHASES          = 12;
    localparam int BEATS_PER_PHASE = 83;
    localparam int QUIET_PHASES    = 2;   // closing phases run with no idling at all
    localparam int SETTLE_CYCLES   = 4;   // covers the pixel pipeline, plus margin

    // codes the package leaves unnamed
    localparam logic [1:0]           MODE_SPARE   = 2'd3;  // unused mode, acts as per-band
    localparam logic [1:0]           SEL_NONE     = 2'd3;  // table select with no table behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;  // first index with no register

    // one input beat, pixel or table write
    typedef struct packed {
        logic       req_type;
        t_pix       band0;
        t_pix       band1;
        t_pix       band2;
        logic       last_in_line;
        logic [1:0] table_select;
        t_pix       table_index;
        t_field     table_value;
    } px_beat_t;

    // one result beat
    typedef struct packed {
        t_field out0;
        t_field out1;
        t_field out2;
        logic   line_done;
    } mapped_px_t;

    // directed rows: p0..p2 are the bands of a pixel, select and index of a load,
    // or register index and data; e0 doubles as the value of a load
    typedef enum logic [1:0] {
        ROW_PIXEL,
        ROW_LOAD,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        t_pix      p0;
        t_pix      p1;
        t_pix      p2;
        logic      last;
        logic      chk;   // expected result typed in the row
        t_field    e0;
        t_field    e1;
        t_field    e2;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [31] = '{
        // corner entries of every table, then a write to a table that does not exist
        '{ROW_LOAD, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0000, 16'h0, 16'h0},
        '{ROW_LOAD, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 16'hFFFF, 16'h0, 16'h0},
        '{ROW_LOAD, 8'd1, 8'd0, 8'd0, 1'b0, 1'b0, 16'h1234, 16'h0, 16'h0},
        '{ROW_LOAD, 8'd1, 8'd255, 8'd0, 1'b0, 1'b0, 16'hABCD, 16'h0, 16'h0},
        '{ROW_LOAD, 8'd2, 8'd0, 8'd0, 1'b0, 1'b0, 16'h8001, 16'h0, 16'h0},
        '{ROW_LOAD, 8'd2, 8'd255, 8'd0, 1'b0, 1'b0, 16'h7FFE, 16'h0, 16'h0},
        '{ROW_LOAD, 8'(SEL_NONE), 8'd255, 8'd0, 1'b0, 1'b0, 16'hDEAD, 16'h0, 16'h0},
        // reset settings: every band mapped
        '{ROW_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 16'h0000, 16'h1234, 16'h8001},
        '{ROW_PIXEL, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 16'hFFFF, 16'hABCD, 16'h7FFE},
        '{ROW_PIXEL, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        // every band passed through
        '{ROW_REG, 8'(REG_BAND_MASK), 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 8'd255, 8'd0, 8'd170, 1'b1, 1'b1, 16'h00FF, 16'h0000, 16'h00AA},
        // mixed mask, zero flag on a mapped band
        '{ROW_REG, 8'(REG_BAND_MASK), 8'd5, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_REG, 8'(REG_ZERO_OUTPUT), 8'd4, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 8'd255, 8'd255, 8'd0, 1'b0, 1'b1, 16'hFFFF, 16'h00FF, 16'h0000},
        // explode, mask ignored
        '{ROW_REG, 8'(REG_MODE), 8'(MODE_EXPLODE), 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_REG, 8'(REG_ZERO_OUTPUT), 8'd2, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 8'd255, 8'd3, 8'd9, 1'b0, 1'b1, 16'hFFFF, 16'h0000, 16'h7FFE},
        // combine with full weights, sum wraps to a byte
        '{ROW_REG, 8'(REG_MODE), 8'(MODE_COMBINE), 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_REG, 8'(REG_MULT0), 8'd255, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_REG, 8'(REG_MULT1), 8'd255, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_REG, 8'(REG_MULT2), 8'd255, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_REG, 8'(REG_ZERO_OUTPUT), 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 8'd1, 8'd1, 8'd255, 1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'h0000},
        '{ROW_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_REG, 8'(REG_ZERO_OUTPUT), 8'd1, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 8'd1, 8'd1, 8'd255, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000},
        // unused mode code falls back to per-band
        '{ROW_REG, 8'(REG_MODE), 8'(MODE_SPARE), 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_REG, 8'(REG_BAND_MASK), 8'd7, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_REG, 8'(REG_ZERO_OUTPUT), 8'd0, 8'd0, 1'b0, 1'b0, 16'h0, 16'h0, 16'h0},
        '{ROW_PIXEL, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 16'h0000, 16'hABCD, 16'h8001}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pblm_in_if  pix_if ();
    pblm_cfg_if cfg_if ();
    pblm_out_if res_if ();

    pixel_band_lut_mapper_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mapping model state: own copy of the tables and the registers
    t_value     lut_copy [NUM_TABLES][TABLE_DEPTH];
    t_cfg       reg_copy;
    mapped_px_t mapped_pending [$];   // results owed by the block, oldest first
    int         fail_count = 0;

    // typed expectation of the beat on the wire, set by the driver
    logic       typed_on = 1'b0;
    mapped_px_t typed_res;

    // idling controls
    logic pix_gap_on   = 1'b0;
    logic res_stall_on = 1'b0;

    // one band through its table, honoring the zero flag
    function automatic t_value band_lut(input int band, input t_pix idx);
        if (reg_copy.zero_output[band]) begin
            return '0;
        end
        return lut_copy[band][int'(idx) % TABLE_DEPTH];
    endfunction

    // expected result of one pixel beat under the current registers
    function automatic mapped_px_t map_pixel(input px_beat_t bt);
        t_pix        bands [NUM_TABLES];
        t_value      v [NUM_TABLES];
        logic [31:0] mix;
        mapped_px_t  r;
        bands = '{bt.band0, bt.band1, bt.band2};
        v = '{default: '0};
        if (reg_copy.mode == MODE_EXPLODE) begin
            // band 0 through all tables, mask ignored
            for (int i = 0; i < NUM_TABLES && i < BAND_COUNT; i++) begin
                v[i] = band_lut(i, bands[0]);
            end
        end else if (reg_copy.mode == MODE_COMBINE) begin
            // weighted sum, low byte indexes table 0, other outputs stay zero
            mix = 32'(reg_copy.mult0) * 32'(bands[0]);
            if (BAND_COUNT > 1) mix += 32'(reg_copy.mult1) * 32'(bands[1]);
            if (BAND_COUNT > 2) mix += 32'(reg_copy.mult2) * 32'(bands[2]);
            v[0] = band_lut(0, mix[7:0]);
        end else begin
            // per-band, also taken by the unused mode code
            for (int i = 0; i < NUM_TABLES && i < BAND_COUNT; i++) begin
                if (reg_copy.band_mask[i]) begin
                    v[i] = band_lut(i, bands[i]);
                end else begin
                    v[i] = t_value'(bands[i]);   // pass-through ignores zero flag
                end
            end
        end
        r.out0      = FIELD_W'(v[0]);
        r.out1      = FIELD_W'(v[1]);
        r.out2      = FIELD_W'(v[2]);
        r.line_done = bt.last_in_line;
        return r;
    endfunction

    // all fields random, callers overwrite what matters
    function automatic px_beat_t noise_beat();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(px_beat_t)-1:0];
    endfunction

    // all accepted beats are seen here at the rising edge
    always @(posedge i_clk) begin
        mapped_px_t got;
        mapped_px_t want;
        px_beat_t   bt;
        if (i_rst_n) begin
            // result side first
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.out0, res_if.out1, res_if.out2, res_if.line_done};
                if (mapped_pending.size() == 0) begin
                    $error("result beat with no pixel pending: %h", got);
                    fail_count++;
                end else begin
                    want = mapped_pending.pop_front();
                    if (got.out0 !== want.out0) begin
                        $error("out0: expected %h, got %h", want.out0, got.out0);
                        fail_count++;
                    end
                    if (got.out1 !== want.out1) begin
                        $error("out1: expected %h, got %h", want.out1, got.out1);
                        fail_count++;
                    end
                    if (got.out2 !== want.out2) begin
                        $error("out2: expected %h, got %h", want.out2, got.out2);
                        fail_count++;
                    end
                    if (got.line_done !== want.line_done) begin
                        $error("line_done: expected %b, got %b", want.line_done,
                               got.line_done);
                        fail_count++;
                    end
                end
            end
            // register writes, data kept to register width
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_MODE:        reg_copy.mode        = cfg_if.data[1:0];
                    REG_BAND_MASK:   reg_copy.band_mask   = cfg_if.data[2:0];
                    REG_MULT0:       reg_copy.mult0       = cfg_if.data;
                    REG_MULT1:       reg_copy.mult1       = cfg_if.data;
                    REG_MULT2:       reg_copy.mult2       = cfg_if.data;
                    REG_ZERO_OUTPUT: reg_copy.zero_output = cfg_if.data[2:0];
                    default: ;
                endcase
            end
            // input side: table writes update the copy, pixels owe a result
            if (pix_if.valid && pix_if.ready) begin
                bt = '{pix_if.req_type, pix_if.band0, pix_if.band1, pix_if.band2,
                       pix_if.last_in_line, pix_if.table_select, pix_if.table_index,
                       pix_if.table_value};
                if (bt.req_type == REQ_TABLE) begin
                    // write to a missing table is dropped
                    if (int'(bt.table_select) < NUM_TABLES &&
                        int'(bt.table_select) < BAND_COUNT) begin
                        lut_copy[bt.table_select][int'(bt.table_index) % TABLE_DEPTH] =
                            t_value'(bt.table_value);
                    end
                end else if (typed_on) begin
                    mapped_pending.push_back(typed_res);
                end else begin
                    mapped_pending.push_back(map_pixel(bt));
                end
            end
        end
    end

    // result sink, ready dropped in random bursts
    initial begin : result_sink
        int hold;
        hold = 0;
        res_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (res_stall_on && hold == 0 && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 13);
            end
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                hold--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // one input beat; starts and ends just after a falling edge, valid left high
    task automatic send_beat(input px_beat_t bt, input logic chk, input mapped_px_t want);
        if (pix_gap_on && $urandom_range(0, 3) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        pix_if.valid        <= 1'b1;
        pix_if.req_type     <= bt.req_type;
        pix_if.band0        <= bt.band0;
        pix_if.band1        <= bt.band1;
        pix_if.band2        <= bt.band2;
        pix_if.last_in_line <= bt.last_in_line;
        pix_if.table_select <= bt.table_select;
        pix_if.table_index  <= bt.table_index;
        pix_if.table_value  <= bt.table_value;
        typed_on  = chk;
        typed_res = want;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_pix data);
        pix_if.valid <= 1'b0;
        while (mapped_pending.size() != 0) @(negedge i_clk);
        // table writes leave nothing to wait for, give them time to land
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        dir_row_t   row;
        px_beat_t   bt;
        mapped_px_t want;
        logic [1:0] mode_v;
        logic [2:0] mask_v;
        logic [2:0] zero_v;
        t_pix       m0, m1, m2;

        // everything known from time zero
        i_rst_n             = 1'b0;
        pix_if.valid        = 1'b0;
        pix_if.req_type     = REQ_PIXEL;
        pix_if.band0        = '0;
        pix_if.band1        = '0;
        pix_if.band2        = '0;
        pix_if.last_in_line = 1'b0;
        pix_if.table_select = '0;
        pix_if.table_index  = '0;
        pix_if.table_value  = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = '0;
        cfg_if.data         = '0;
        typed_res           = '0;

        // model registers at their reset values, tables never read before written
        reg_copy = '{MODE_RST, BAND_MASK_RST, MULT0_RST, MULT1_RST, MULT2_RST, ZERO_OUT_RST};
        foreach (lut_copy[t, i]) lut_copy[t][i] = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows with idling on both sides
        pix_gap_on   = 1'b1;
        res_stall_on = 1'b1;
        foreach (DIRECTED_ROWS[r]) begin
            row = DIRECTED_ROWS[r];
            bt  = noise_beat();
            case (row.kind)
                ROW_REG: begin
                    write_reg(row.p0[CFG_IDX_W-1:0], row.p1);
                end
                ROW_LOAD: begin
                    bt.req_type     = REQ_TABLE;
                    bt.table_select = row.p0[1:0];
                    bt.table_index  = row.p1;
                    bt.table_value  = row.e0;
                    send_beat(bt, 1'b0, '0);
                end
                default: begin
                    bt.req_type     = REQ_PIXEL;
                    bt.band0        = row.p0;
                    bt.band1        = row.p1;
                    bt.band2        = row.p2;
                    bt.last_in_line = row.last;
                    want = '{row.e0, row.e1, row.e2, row.last};
                    send_beat(bt, row.chk, want);
                end
            endcase
        end

        // load every entry so random pixels never hit an unwritten one
        for (int t = 0; t < NUM_TABLES; t++) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                bt = noise_beat();
                bt.req_type     = REQ_TABLE;
                bt.table_select = 2'(t);
                bt.table_index  = t_pix'(i);
                send_beat(bt, 1'b0, '0);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            mode_v = 2'($urandom_range(0, 3));
            mask_v = 3'($urandom);
            m0     = t_pix'($urandom);
            m1     = t_pix'($urandom);
            m2     = t_pix'($urandom);
            zero_v = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom);
            case (ph)
                0: begin   // all registers at their low end
                    mode_v = MODE_PER_BAND;
                    mask_v = '0;
                    m0 = '0;
                    m1 = '0;
                    m2 = '0;
                    zero_v = '0;
                end
                1: begin   // all registers at their high end
                    mode_v = MODE_SPARE;
                    mask_v = '1;
                    m0 = '1;
                    m1 = '1;
                    m2 = '1;
                    zero_v = '1;
                end
                2: begin
                    mode_v = MODE_COMBINE;
                    m0 = '1;
                    m1 = '1;
                    m2 = '1;
                    zero_v = '0;
                end
                3: begin
                    mode_v = MODE_EXPLODE;
                    zero_v = '0;
                end
                default: ;
            endcase

            // upper data bits carry noise, the registers keep only their width
            write_reg(REG_MODE,        {6'($urandom), mode_v});
            write_reg(REG_BAND_MASK,   {5'($urandom), mask_v});
            write_reg(REG_MULT0,       m0);
            write_reg(REG_MULT1,       m1);
            write_reg(REG_MULT2,       m2);
            write_reg(REG_ZERO_OUTPUT, {5'($urandom), zero_v});
            if ($urandom_range(0, 2) == 0) begin
                // write to an index with no register behind it
                write_reg(REG_UNMAPPED | CFG_IDX_W'($urandom_range(0, 1)), t_pix'($urandom));
            end

            // idling varies per phase, the closing phases run flat out
            pix_gap_on   = (ph < PHASES - QUIET_PHASES) && ($urandom_range(0, 2) != 0);
            res_stall_on = (ph < PHASES - QUIET_PHASES) && ($urandom_range(0, 2) != 0);

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                bt = noise_beat();
                if ($urandom_range(0, 99) < 15) begin
                    // table update, some aimed at the missing table
                    bt.req_type = REQ_TABLE;
                    bt.table_select = ($urandom_range(0, 4) == 0) ? SEL_NONE
                                                                  : 2'($urandom_range(0, 2));
                    if ($urandom_range(0, 7) == 0) begin
                        bt.table_value = $urandom_range(0, 1) ? '1 : '0;
                    end
                end else begin
                    bt.req_type = REQ_PIXEL;
                    // pull bands to their extremes now and then
                    if ($urandom_range(0, 7) == 0) bt.band0 = $urandom_range(0, 1) ? '1 : '0;
                    if ($urandom_range(0, 7) == 0) bt.band1 = $urandom_range(0, 1) ? '1 : '0;
                    if ($urandom_range(0, 7) == 0) bt.band2 = $urandom_range(0, 1) ? '1 : '0;
                end
                send_beat(bt, 1'b0, '0);
            end
        end

        // drain and let the pipeline empty
        pix_if.valid <= 1'b0;
        while (mapped_pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
